// ===== hdl/rta_pkg.sv =====
// ----------------------------------------------------------------------------
// rta_pkg
// Types and constants shared by the region table allocator and its cells.
// ----------------------------------------------------------------------------
package rta_pkg;

  // Arithmetic width for addresses and sums (start + length + length)
  localparam int CALC_W     = 17;
  // Wide enough for any slot number in the supported range
  localparam int SLOT_IDX_W = 6;
  // Active slot count, up to the largest slot count
  localparam int ACT_W      = 7;
  localparam int ADDR_W     = 13;
  localparam int VER_W      = 8;
  localparam int CFG_IDX_W  = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_FLOOR = 1'b1;

  // Request modes
  localparam logic [2:0] MODE_FIRST_FIT  = 3'd0;
  localparam logic [2:0] MODE_AFTER_LAST = 3'd1;
  localparam logic [2:0] MODE_AFTER_SLOT = 3'd2;
  localparam logic [2:0] MODE_AT_ADDR    = 3'd3;
  localparam logic [2:0] MODE_RESIZE     = 3'd4;
  localparam logic [2:0] MODE_READ       = 3'd5;

  typedef enum logic [2:0] {
    STAT_OK             = 3'd0,
    STAT_TOO_LARGE      = 3'd1,
    STAT_NO_SLOT        = 3'd2,
    STAT_NO_SPACE       = 3'd3,
    STAT_NO_SPACE_AFTER = 3'd4,
    STAT_BAD_ARG        = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SEL,
    ST_CHK,
    ST_FIN
  } state_t;

  // Running result handed from cell to cell along the chain
  typedef struct packed {
    logic                  fe_ok;
    logic [SLOT_IDX_W-1:0] fe_idx;
    logic                  any_occ;
    logic                  lst_ok;
    logic [SLOT_IDX_W-1:0] lst_idx;
    logic [ADDR_W-1:0]     lst_start;
    logic                  ff_ok;
    logic [ADDR_W-1:0]     ff_start;
    logic [ADDR_W:0]       ff_end;
    logic [ADDR_W-1:0]     ref_start;
    logic [ADDR_W-1:0]     ref_len;
    logic [VER_W-1:0]      ref_ver;
    logic                  ref_gapok;
    logic                  clash;
  } acc_t;

  localparam acc_t ACC_INIT = '0;

  // Entry travelling round the ring for the gap search
  typedef struct packed {
    logic [ADDR_W-1:0]     start;
    logic [SLOT_IDX_W-1:0] idx;
    logic                  occ;
  } vis_t;

  // Controls and operands broadcast from the sequencer to every cell
  typedef struct packed {
    logic [ACT_W-1:0]      active;
    logic [ADDR_W-1:0]     req_len;
    logic [ADDR_W-1:0]     ref_idx;
    logic [CALC_W-1:0]     z_addr;
    logic                  skip_en;
    logic [SLOT_IDX_W-1:0] skip_idx;
    logic                  ring_load;
    logic                  ring_shift;
    logic                  wr_en;
    logic                  wr_len_only;
    logic [SLOT_IDX_W-1:0] wr_idx;
    logic [ADDR_W-1:0]     wr_start;
    logic [ADDR_W-1:0]     wr_len;
    logic [VER_W-1:0]      wr_ver;
  } bcast_t;

endpackage

// ===== hdl/rta_intf.sv =====
// ----------------------------------------------------------------------------
// rta_req_if / rta_rsp_if
// Valid/ready channels for requests and results of the region allocator.
// ----------------------------------------------------------------------------
interface rta_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [12:0] target;
  logic [12:0] length;
  logic [7:0]  tag_version;

  modport source (output valid, output mode, output target, output length,
                  output tag_version, input ready);
  modport sink   (input valid, input mode, input target, input length,
                  input tag_version, output ready);
endinterface

interface rta_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  slot;
  logic [12:0] start_res;
  logic [12:0] extent;
  logic [7:0]  stored_version;

  modport source (output valid, output status, output slot, output start_res,
                  output extent, output stored_version, input ready);
  modport sink   (input valid, input status, input slot, input start_res,
                  input extent, input stored_version, output ready);
endinterface

// ===== hdl/region_table_allocator.sv =====
// Requests are handled one at a time; each takes up to three sweeps along the
// cell chain (ring scan, selection, overlap check), the overlap check sweep only
// when the request needs it, before the result is offered.
// A new request is taken while the previous result beat still waits.
// Reset empties every slot at once, slots_in_use = 16, region_floor = 0.
// ----------------------------------------------------------------------------
// region_table_allocator
// First-fit region table built as a chain of slot cells with a sequencer.
// ----------------------------------------------------------------------------
module region_table_allocator #(
  parameter int NUM_SLOTS = 16,
  parameter int MEM_BYTES = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  rta_req_if.sink                         req,
  rta_rsp_if.source                       rsp,
  input  logic                            cfg_write,
  input  logic [rta_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rta_pkg::ADDR_W-1:0]      cfg_data
);

  localparam int CW    = rta_pkg::CALC_W;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_SLOTS);
  localparam logic [CW-1:0]    MEM_C    = CW'(MEM_BYTES);
  localparam logic [rta_pkg::ACT_W-1:0] NUM_ACT = rta_pkg::ACT_W'(NUM_SLOTS);

  // Configuration
  logic [4:0]                 slots_in_use;
  logic [rta_pkg::ADDR_W-1:0] region_floor;
  logic [rta_pkg::ACT_W-1:0]  active;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= 5'd16;
      region_floor <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        rta_pkg::CFG_SLOTS_IN_USE: slots_in_use <= cfg_data[4:0];
        rta_pkg::CFG_REGION_FLOOR: region_floor <= cfg_data;
        default: ;
      endcase
    end
  end

  assign active = (rta_pkg::ACT_W'(slots_in_use) > NUM_ACT) ? NUM_ACT
                                                            : rta_pkg::ACT_W'(slots_in_use);

  // Sequencer state
  rta_pkg::state_t state, state_next;
  logic [CNT_W-1:0] cnt;
  logic             last;

  logic [2:0]                     r_mode;
  logic [rta_pkg::ADDR_W-1:0]     r_target;
  logic [rta_pkg::ADDR_W-1:0]     r_len;
  logic [rta_pkg::VER_W-1:0]      r_ver;
  logic                           a_fe_ok;
  logic [rta_pkg::SLOT_IDX_W-1:0] a_fe_idx;
  logic                           a_any;
  logic [rta_pkg::SLOT_IDX_W-1:0] a_lst_idx;
  logic [CW-1:0]                  s_addr;
  logic                           s_resize;
  logic [rta_pkg::ADDR_W-1:0]     s_ref_start;
  logic [rta_pkg::VER_W-1:0]      s_ref_ver;

  // Pending result
  rta_pkg::status_t           res_status;
  logic [3:0]                 res_slot;
  logic [rta_pkg::ADDR_W-1:0] res_start;
  logic [rta_pkg::ADDR_W-1:0] res_extent;
  logic [rta_pkg::VER_W-1:0]  res_ver;

  logic rsp_valid;
  logic accept;
  logic rsp_load;

  rta_pkg::bcast_t bc;
  rta_pkg::acc_t   acc [NUM_SLOTS+1];
  rta_pkg::vis_t   vis [NUM_SLOTS];
  rta_pkg::acc_t   acc_end;

  assign acc[0]   = rta_pkg::ACC_INIT;
  assign acc_end  = acc[NUM_SLOTS];
  assign last     = (cnt == CNT_LAST);
  assign accept   = req.valid && req.ready;
  assign req.ready = (state == rta_pkg::ST_IDLE);
  assign rsp_load = (state == rta_pkg::ST_FIN) && (!rsp_valid || rsp.ready);

  // Cell chain and ring
  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
    localparam int PREV = (k == 0) ? NUM_SLOTS - 1 : k - 1;
    rta_cell #(.K(k), .MEM_BYTES(MEM_BYTES)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .bc      (bc),
      .acc_in  (acc[k]),
      .acc_out (acc[k+1]),
      .vis_in  (vis[PREV]),
      .vis_out (vis[k])
    );
  end

  // Decision after the selection sweep
  logic [CW-1:0]    maxlen;
  logic             tgt_act;
  logic [CW-1:0]    ref_end;
  rta_pkg::status_t d_status;
  logic             d_chk;
  logic             d_resize;
  logic             d_read;
  logic [CW-1:0]    d_addr;
  logic             d_ok;

  assign maxlen  = (CW'(region_floor) >= MEM_C) ? '0 : (MEM_C - CW'(region_floor));
  assign tgt_act = r_target < rta_pkg::ADDR_W'(active);
  assign ref_end = CW'(acc_end.ref_start) + CW'(acc_end.ref_len);
  assign d_ok    = (d_status == rta_pkg::STAT_OK);

  always_comb begin
    d_status = rta_pkg::STAT_BAD_ARG;
    d_chk    = 1'b0;
    d_resize = 1'b0;
    d_read   = 1'b0;
    d_addr   = '0;
    case (r_mode)
      rta_pkg::MODE_FIRST_FIT, rta_pkg::MODE_AFTER_LAST,
      rta_pkg::MODE_AFTER_SLOT, rta_pkg::MODE_AT_ADDR: begin
        if (CW'(r_len) > maxlen) begin
          d_status = rta_pkg::STAT_TOO_LARGE;
        end else if (!a_fe_ok) begin
          d_status = rta_pkg::STAT_NO_SLOT;
        end else if (r_mode == rta_pkg::MODE_AT_ADDR) begin
          d_chk  = 1'b1;
          d_addr = CW'(r_target);
        end else if (r_mode == rta_pkg::MODE_AFTER_SLOT) begin
          if (!(tgt_act && (acc_end.ref_len != '0))) begin
            d_status = rta_pkg::STAT_BAD_ARG;
          end else if (acc_end.ref_gapok) begin
            d_chk  = 1'b1;
            d_addr = ref_end;
          end else begin
            d_status = rta_pkg::STAT_NO_SPACE_AFTER;
          end
        end else if (r_mode == rta_pkg::MODE_FIRST_FIT) begin
          if (!a_any) begin
            d_chk  = 1'b1;
            d_addr = CW'(region_floor);
          end else if (!acc_end.ff_ok) begin
            d_status = rta_pkg::STAT_NO_SPACE;
          end else begin
            d_chk  = 1'b1;
            d_addr = CW'(acc_end.ff_end);
          end
        end else begin
          if (!a_any) begin
            d_chk  = 1'b1;
            d_addr = MEM_C - CW'(r_len);
          end else if (acc_end.ref_gapok) begin
            d_chk  = 1'b1;
            d_addr = ref_end;
          end else begin
            d_status = rta_pkg::STAT_NO_SPACE_AFTER;
          end
        end
      end
      rta_pkg::MODE_RESIZE: begin
        if (tgt_act) begin
          d_resize = 1'b1;
          if (r_len > acc_end.ref_len) begin
            d_chk  = 1'b1;
            d_addr = CW'(acc_end.ref_start);
          end else begin
            d_status = rta_pkg::STAT_OK;
          end
        end
      end
      rta_pkg::MODE_READ: begin
        if (tgt_act) begin
          d_read   = 1'b1;
          d_status = rta_pkg::STAT_OK;
        end
      end
      default: ;
    endcase
  end

  // Bounds and overlap verdict after the check sweep
  logic [CW-1:0] z_end;
  logic          c_ok;

  assign z_end = s_addr + CW'(r_len);
  assign c_ok  = (s_addr <= MEM_C) && (CW'(r_len) <= MEM_C) && (z_end <= MEM_C) &&
                 (s_addr >= CW'(region_floor)) && !acc_end.clash;

  // Next state and broadcast controls
  always_comb begin
    state_next     = state;
    bc             = '0;
    bc.active      = active;
    bc.req_len     = r_len;
    bc.ref_idx     = (r_mode == rta_pkg::MODE_AFTER_LAST)
                     ? rta_pkg::ADDR_W'(a_lst_idx) : r_target;
    bc.z_addr      = s_addr;
    bc.skip_en     = s_resize;
    bc.skip_idx    = r_target[rta_pkg::SLOT_IDX_W-1:0];
    bc.ring_load   = accept;
    bc.wr_idx      = s_resize ? r_target[rta_pkg::SLOT_IDX_W-1:0] : a_fe_idx;
    bc.wr_start    = s_addr[rta_pkg::ADDR_W-1:0];
    bc.wr_len      = r_len;
    bc.wr_ver      = r_ver;
    bc.wr_len_only = s_resize;
    case (state)
      rta_pkg::ST_IDLE: begin
        if (accept) state_next = rta_pkg::ST_SCAN;
      end
      rta_pkg::ST_SCAN: begin
        bc.ring_shift = 1'b1;
        if (last) state_next = rta_pkg::ST_SEL;
      end
      rta_pkg::ST_SEL: begin
        if (last) begin
          state_next = d_chk ? rta_pkg::ST_CHK : rta_pkg::ST_FIN;
          // resize without growth is written straight away
          if (!d_chk && d_resize && (d_status == rta_pkg::STAT_OK)) begin
            bc.wr_en       = 1'b1;
            bc.wr_len_only = 1'b1;
            bc.wr_idx      = r_target[rta_pkg::SLOT_IDX_W-1:0];
          end
        end
      end
      rta_pkg::ST_CHK: begin
        if (last) begin
          state_next = rta_pkg::ST_FIN;
          bc.wr_en   = c_ok;
        end
      end
      rta_pkg::ST_FIN: begin
        if (rsp_load) state_next = rta_pkg::ST_IDLE;
      end
      default: state_next = rta_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rta_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state != state_next) cnt <= '0;
      else if (!last)          cnt <= cnt + 1'b1;
    end
  end

  // Request capture, sweep results and pending result
  always_ff @(posedge clk) begin
    if (accept) begin
      r_mode   <= req.mode;
      r_target <= req.target;
      r_len    <= req.length;
      r_ver    <= req.tag_version;
    end
    if ((state == rta_pkg::ST_SCAN) && last) begin
      a_fe_ok   <= acc_end.fe_ok;
      a_fe_idx  <= acc_end.fe_idx;
      a_any     <= acc_end.any_occ;
      a_lst_idx <= acc_end.lst_idx;
    end
    if ((state == rta_pkg::ST_SEL) && last) begin
      s_addr      <= d_addr;
      s_resize    <= d_resize;
      s_ref_start <= acc_end.ref_start;
      s_ref_ver   <= acc_end.ref_ver;
      res_status  <= d_status;
      res_slot    <= d_ok ? r_target[3:0] : '0;
      res_start   <= d_ok ? acc_end.ref_start : '0;
      res_extent  <= d_ok ? (d_read ? acc_end.ref_len : r_len) : '0;
      res_ver     <= d_ok ? acc_end.ref_ver : '0;
    end
    if ((state == rta_pkg::ST_CHK) && last) begin
      res_status <= c_ok ? rta_pkg::STAT_OK : rta_pkg::STAT_NO_SPACE;
      res_slot   <= !c_ok ? '0 : (s_resize ? r_target[3:0] : a_fe_idx[3:0]);
      res_start  <= !c_ok ? '0 : (s_resize ? s_ref_start : s_addr[rta_pkg::ADDR_W-1:0]);
      res_extent <= c_ok ? r_len : '0;
      res_ver    <= !c_ok ? '0 : (s_resize ? s_ref_ver : r_ver);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.status         <= res_status;
      rsp.slot           <= res_slot;
      rsp.start_res      <= res_start;
      rsp.extent         <= res_extent;
      rsp.stored_version <= res_ver;
    end
  end

  assign rsp.valid = rsp_valid;

  // Assertions
  a_wr_phase : assert property (@(posedge clk) disable iff (rst)
    bc.wr_en |-> (state == rta_pkg::ST_SEL || state == rta_pkg::ST_CHK))
    else $error("table write outside a decision cycle");

  a_accept_scan : assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == rta_pkg::ST_SCAN && cnt == '0))
    else $error("accepted beat did not start a scan");

  a_err_zero : assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != rta_pkg::STAT_OK) |->
      (rsp.slot == '0 && rsp.start_res == '0 && rsp.extent == '0 &&
       rsp.stored_version == '0))
    else $error("error result carries entry data");

  a_cnt_range : assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_LAST)
    else $error("sweep counter out of range");

endmodule

// ===== hdl/rta_cell.sv =====
// ----------------------------------------------------------------------------
// rta_cell
// One table slot: holds its entry, finds its successor as the ring turns and
// folds itself into the running result passed along the chain.
// ----------------------------------------------------------------------------
module rta_cell #(
  parameter int K         = 0,
  parameter int MEM_BYTES = 4096
) (
  input  logic            clk,
  input  logic            rst,
  input  rta_pkg::bcast_t bc,
  input  rta_pkg::acc_t   acc_in,
  output rta_pkg::acc_t   acc_out,
  input  rta_pkg::vis_t   vis_in,
  output rta_pkg::vis_t   vis_out
);

  localparam int CW = rta_pkg::CALC_W;
  localparam logic [rta_pkg::SLOT_IDX_W-1:0] K_IDX = rta_pkg::SLOT_IDX_W'(K);
  localparam logic [rta_pkg::ACT_W-1:0]      K_ACT = rta_pkg::ACT_W'(K);
  localparam logic [rta_pkg::ADDR_W-1:0]     K_TGT = rta_pkg::ADDR_W'(K);
  localparam logic [CW-1:0]                  MEM_C = CW'(MEM_BYTES);

  logic [rta_pkg::ADDR_W-1:0] start;
  logic [rta_pkg::ADDR_W-1:0] len;
  logic [rta_pkg::VER_W-1:0]  ver;
  logic [CW-1:0]              nxt;
  rta_pkg::vis_t              vis;
  rta_pkg::acc_t              acc_next;

  logic          occ;
  logic [CW-1:0] end_c;
  logic [CW-1:0] z_end;
  logic          gapok;
  logic          vis_after;

  assign occ       = (K_ACT < bc.active) && (len != '0);
  assign end_c     = CW'(start) + CW'(len);
  assign z_end     = bc.z_addr + CW'(bc.req_len);
  // gap after this entry is larger than the request
  assign gapok     = nxt > (end_c + CW'(bc.req_len));
  assign vis_after = (vis.start > start) || ((vis.start == start) && (vis.idx > K_IDX));
  assign vis_out   = vis;

  // Table entry
  always_ff @(posedge clk) begin
    if (rst) begin
      start <= '0;
      len   <= '0;
      ver   <= '0;
    end else if (bc.wr_en && (bc.wr_idx == K_IDX)) begin
      len <= bc.wr_len;
      if (!bc.wr_len_only) begin
        start <= bc.wr_start;
        ver   <= bc.wr_ver;
      end
    end
  end

  // Ring: nearest following start among the visitors
  always_ff @(posedge clk) begin
    if (bc.ring_load) begin
      vis.start <= start;
      vis.idx   <= K_IDX;
      vis.occ   <= occ;
      nxt       <= MEM_C;
    end else if (bc.ring_shift) begin
      vis <= vis_in;
      if (vis.occ && (vis.idx != K_IDX) && vis_after && (CW'(vis.start) < nxt)) begin
        nxt <= CW'(vis.start);
      end
    end
  end

  // Fold this slot into the running result
  always_comb begin
    acc_next = acc_in;
    if (!acc_in.fe_ok && (K_ACT < bc.active) && (len == '0)) begin
      acc_next.fe_ok  = 1'b1;
      acc_next.fe_idx = K_IDX;
    end
    if (occ) begin
      acc_next.any_occ = 1'b1;
    end
    // later cell with equal start sorts after
    if (occ && (!acc_in.lst_ok || (start >= acc_in.lst_start))) begin
      acc_next.lst_ok    = 1'b1;
      acc_next.lst_idx   = K_IDX;
      acc_next.lst_start = start;
    end
    if (occ && gapok && (!acc_in.ff_ok || (start < acc_in.ff_start))) begin
      acc_next.ff_ok    = 1'b1;
      acc_next.ff_start = start;
      acc_next.ff_end   = end_c[rta_pkg::ADDR_W:0];
    end
    if (bc.ref_idx == K_TGT) begin
      acc_next.ref_start = start;
      acc_next.ref_len   = len;
      acc_next.ref_ver   = ver;
      acc_next.ref_gapok = gapok;
    end
    if (occ && !(bc.skip_en && (bc.skip_idx == K_IDX))) begin
      if ((bc.z_addr >= CW'(start)) && (bc.z_addr < end_c)) acc_next.clash = 1'b1;
      if ((z_end > CW'(start)) && (z_end <= end_c))         acc_next.clash = 1'b1;
      if ((bc.z_addr < CW'(start)) && (z_end >= end_c))     acc_next.clash = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    acc_out <= acc_next;
  end

endmodule

// ===== tb/sv/tb_region_table_allocator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_region_table_allocator
// Self-checking bench for the region table allocator. A directed table and
// then random request streams are sent over the request channel. Each result
// beat is compared field by field with a queue filled by a behavioural
// model of the slot table or by fixed directed rows. Settings of both registers change between phases.
// ----------------------------------------------------------------------------
module tb_region_table_allocator;

  localparam int NSLOT = 16;
  localparam int MEMB  = 4096;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [12:0] start_res;
    logic [12:0] extent;
    logic [7:0]  stored_version;
  } alloc_res_t;

  typedef struct {
    logic [2:0]  mode;
    logic [12:0] target;
    logic [12:0] length;
    logic [7:0]  tag_version;
    bit          fixed;
    alloc_res_t  want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [rta_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rta_pkg::ADDR_W-1:0] cfg_data = '0;

  rta_req_if req ();
  rta_rsp_if rsp ();

  region_table_allocator u_top (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Model state of the slot table
  int tbl_start [NSLOT];
  int tbl_len   [NSLOT];
  int tbl_ver   [NSLOT];
  int act_cfg   = 16;
  int floor_cfg = 0;

  alloc_res_t pending_results[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  bit sending_done = 1'b0;

  function automatic int n_active();
    return act_cfg > NSLOT ? NSLOT : act_cfg;
  endfunction

  function automatic bit occupied(int i);
    return i < n_active() && tbl_len[i] != 0;
  endfunction

  function automatic bit later(int j, int i);
    return tbl_start[j] > tbl_start[i] || (tbl_start[j] == tbl_start[i] && j > i);
  endfunction

  function automatic int gap_of(int i);
    int nxt;
    int e;
    nxt = MEMB;
    e = tbl_start[i] + tbl_len[i];
    for (int j = 0; j < n_active(); j++)
      if (j != i && occupied(j) && later(j, i) && tbl_start[j] < nxt) nxt = tbl_start[j];
    return nxt > e ? nxt - e : 0;
  endfunction

  function automatic bit free_zone(int addr, int len, int skip);
    int e;
    int a;
    int b;
    e = addr + len;
    if (addr > MEMB || len > MEMB || e > MEMB || addr < floor_cfg) return 1'b0;
    for (int j = 0; j < n_active(); j++) begin
      if (j == skip || !occupied(j)) continue;
      a = tbl_start[j];
      b = a + tbl_len[j];
      if (addr >= a && addr < b) return 1'b0;
      if (e > a && e <= b) return 1'b0;
      if (addr < a && e >= b) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int lowest_empty();
    for (int i = 0; i < n_active(); i++)
      if (tbl_len[i] == 0) return i;
    return -1;
  endfunction

  function automatic rta_pkg::status_t claim(int addr, int len, int ver, ref int id);
    if (!free_zone(addr, len, -1)) return rta_pkg::STAT_NO_SPACE;
    id = lowest_empty();
    if (id < 0) return rta_pkg::STAT_NO_SLOT;
    tbl_start[id] = addr & 'h1FFF;
    tbl_len[id] = len & 'h1FFF;
    tbl_ver[id] = ver & 'hFF;
    return rta_pkg::STAT_OK;
  endfunction

  function automatic rta_pkg::status_t claim_after(int i, int len, int ver, ref int id);
    if (gap_of(i) > len) return claim(tbl_start[i] + tbl_len[i], len, ver, id);
    return rta_pkg::STAT_NO_SPACE_AFTER;
  endfunction

  // Applies one request to the model table and returns its result
  function automatic alloc_res_t allocate(logic [2:0] mode, int tgt, int len, int ver);
    alloc_res_t r;
    rta_pkg::status_t st;
    int id;
    int best;
    int maxlen;
    bit any;
    st = rta_pkg::STAT_BAD_ARG;
    id = 0;
    maxlen = floor_cfg >= MEMB ? 0 : MEMB - floor_cfg;
    if (mode <= rta_pkg::MODE_AT_ADDR) begin
      if (len > maxlen) st = rta_pkg::STAT_TOO_LARGE;
      else if (lowest_empty() < 0) st = rta_pkg::STAT_NO_SLOT;
      else if (mode == rta_pkg::MODE_AT_ADDR) st = claim(tgt, len, ver, id);
      else if (mode == rta_pkg::MODE_AFTER_SLOT)
        st = (tgt < NSLOT && occupied(tgt)) ? claim_after(tgt, len, ver, id)
                                            : rta_pkg::STAT_BAD_ARG;
      else begin
        best = -1;
        any = 1'b0;
        for (int i = 0; i < n_active(); i++) begin
          if (!occupied(i)) continue;
          any = 1'b1;
          if (mode == rta_pkg::MODE_FIRST_FIT) begin
            if (gap_of(i) > len && (best < 0 || later(best, i))) best = i;
          end else if (best < 0 || later(i, best)) begin
            best = i;
          end
        end
        if (mode == rta_pkg::MODE_FIRST_FIT) begin
          if (!any) st = claim(floor_cfg, len, ver, id);
          else if (best < 0) st = rta_pkg::STAT_NO_SPACE;
          else st = claim(tbl_start[best] + tbl_len[best], len, ver, id);
        end else begin
          if (best < 0) st = claim(MEMB - len, len, ver, id);
          else st = claim_after(best, len, ver, id);
        end
      end
    end else if (mode == rta_pkg::MODE_RESIZE) begin
      if (tgt < n_active()) begin
        if (len > tbl_len[tgt] && !free_zone(tbl_start[tgt], len, tgt))
          st = rta_pkg::STAT_NO_SPACE;
        else begin
          tbl_len[tgt] = len;
          id = tgt;
          st = rta_pkg::STAT_OK;
        end
      end
    end else if (mode == rta_pkg::MODE_READ) begin
      if (tgt < n_active()) begin
        id = tgt;
        st = rta_pkg::STAT_OK;
      end
    end
    r = '0;
    r.status = st;
    if (st == rta_pkg::STAT_OK) begin
      r.slot = id[3:0];
      r.start_res = tbl_start[id][12:0];
      r.extent = tbl_len[id][12:0];
      r.stored_version = tbl_ver[id][7:0];
    end
    return r;
  endfunction

  // Result beats: sampled at the rising edge, checked against oldest entry
  always @(posedge clk) begin
    alloc_res_t got;
    alloc_res_t exp_r;
    if (!rst && rsp.valid && rsp.ready) begin
      got = {rsp.status, rsp.slot, rsp.start_res, rsp.extent, rsp.stored_version};
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, got %h", $time, got);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got.status !== exp_r.status)
          $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
        if (got.slot !== exp_r.slot)
          $display("%0t: slot exp %0d got %0d", $time, exp_r.slot, got.slot);
        if (got.start_res !== exp_r.start_res)
          $display("%0t: start exp %0d got %0d", $time, exp_r.start_res, got.start_res);
        if (got.extent !== exp_r.extent)
          $display("%0t: extent exp %0d got %0d", $time, exp_r.extent, got.extent);
        if (got.stored_version !== exp_r.stored_version)
          $display("%0t: version exp %0d got %0d", $time, exp_r.stored_version,
                   got.stored_version);
        if (got !== exp_r) errors++;
      end
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || rst || hold_off)
      idle_cycles <= 0;
    else if (req.valid || pending_results.size() != 0 || !sending_done)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: own stall pattern, always-ready stretches, one long hold-off
  initial begin
    int phase;
    rsp.ready = 1'b0;
    phase = 0;
    @(negedge clk);
    while (1) begin
      @(negedge clk);
      phase++;
      if (hold_off) rsp.ready <= 1'b0;
      else if ((phase / 300) % 3 == 1) rsp.ready <= 1'b1;
      else rsp.ready <= ((phase % 7) < 4) || ($urandom_range(0, 3) == 0);
    end
  end

  task automatic send_beat(logic [2:0] mode, int tgt, int len, int ver, bit gappy);
    req.valid <= 1'b1;
    req.mode <= mode;
    req.target <= tgt[12:0];
    req.length <= len[12:0];
    req.tag_version <= ver[7:0];
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
    if (gappy && $urandom_range(0, 5) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (3 * NSLOT + 10) @(negedge clk);
  endtask

  // One write beat followed by a quiet cycle
  task automatic write_reg(logic [rta_pkg::CFG_IDX_W-1:0] idx, int val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[12:0];
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == rta_pkg::CFG_SLOTS_IN_USE) act_cfg = val & 'h1F;
    else floor_cfg = val & 'h1FFF;
    @(negedge clk);
  endtask

  // Requests are predicted at send time; the block is strictly in order
  task automatic issue(logic [2:0] mode, int tgt, int len, int ver, bit gappy);
    pending_results.push_back(allocate(mode, tgt, len, ver));
    send_beat(mode, tgt, len, ver, gappy);
  endtask

  dir_row_t dir_rows[$];

  function automatic alloc_res_t fixed_res(rta_pkg::status_t st, int s, int a, int l, int v);
    alloc_res_t r;
    r = {st, s[3:0], a[12:0], l[12:0], v[7:0]};
    return r;
  endfunction

  task automatic add_row(logic [2:0] m, int t, int l, int v, bit fx, alloc_res_t w);
    dir_row_t d;
    d.mode = m;
    d.target = t[12:0];
    d.length = l[12:0];
    d.tag_version = v[7:0];
    d.fixed = fx;
    d.want = w;
    dir_rows.push_back(d);
  endtask

  initial begin
    alloc_res_t p;
    logic [2:0] m;
    int len;
    int tgt;
    int burst;
    for (int i = 0; i < NSLOT; i++) begin
      tbl_start[i] = 0; tbl_len[i] = 0; tbl_ver[i] = 0;
    end
    req.valid = 1'b0;
    req.mode = '0;
    req.target = '0;
    req.length = '0;
    req.tag_version = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table: fixed rows are reads of the reset state, errors or a first placement
    add_row(rta_pkg::MODE_READ, 0, 0, 0, 1, fixed_res(rta_pkg::STAT_OK, 0, 0, 0, 0));
    add_row(rta_pkg::MODE_READ, 15, 0, 0, 1, fixed_res(rta_pkg::STAT_OK, 15, 0, 0, 0));
    add_row(rta_pkg::MODE_READ, 16, 0, 0, 1, fixed_res(rta_pkg::STAT_BAD_ARG, 0, 0, 0, 0));
    add_row(3'd6, 0, 5, 1, 1, fixed_res(rta_pkg::STAT_BAD_ARG, 0, 0, 0, 0));
    add_row(3'd7, 8191, 8191, 255, 1, fixed_res(rta_pkg::STAT_BAD_ARG, 0, 0, 0, 0));
    add_row(rta_pkg::MODE_FIRST_FIT, 0, 8191, 0, 1,
            fixed_res(rta_pkg::STAT_TOO_LARGE, 0, 0, 0, 0));
    add_row(rta_pkg::MODE_AFTER_SLOT, 3, 10, 0, 1,
            fixed_res(rta_pkg::STAT_BAD_ARG, 0, 0, 0, 0));
    add_row(rta_pkg::MODE_AFTER_LAST, 0, 100, 7, 1,
            fixed_res(rta_pkg::STAT_OK, 0, 3996, 100, 7));
    add_row(rta_pkg::MODE_FIRST_FIT, 0, 50, 255, 0, '0);
    add_row(rta_pkg::MODE_FIRST_FIT, 0, 4096, 1, 0, '0);
    add_row(rta_pkg::MODE_AT_ADDR, 0, 40, 2, 0, '0);
    add_row(rta_pkg::MODE_FIRST_FIT, 0, 20, 3, 0, '0);
    add_row(rta_pkg::MODE_AFTER_SLOT, 0, 10, 4, 0, '0);
    add_row(rta_pkg::MODE_AT_ADDR, 3990, 20, 5, 0, '0);
    add_row(rta_pkg::MODE_AT_ADDR, 8191, 0, 6, 0, '0);
    add_row(rta_pkg::MODE_AT_ADDR, 4096, 0, 6, 0, '0);
    add_row(rta_pkg::MODE_AFTER_LAST, 0, 0, 9, 0, '0);
    add_row(rta_pkg::MODE_RESIZE, 1, 300, 0, 0, '0);
    add_row(rta_pkg::MODE_RESIZE, 1, 4096, 0, 0, '0);
    add_row(rta_pkg::MODE_RESIZE, 0, 0, 0, 0, '0);
    add_row(rta_pkg::MODE_RESIZE, 0, 30, 0, 0, '0);
    add_row(rta_pkg::MODE_RESIZE, 8191, 1, 0, 0, '0);
    add_row(rta_pkg::MODE_AFTER_SLOT, 8191, 1, 0, 0, '0);
    add_row(rta_pkg::MODE_READ, 1, 0, 0, 0, '0);
    foreach (dir_rows[k]) begin
      p = allocate(dir_rows[k].mode, dir_rows[k].target, dir_rows[k].length,
                   dir_rows[k].tag_version);
      pending_results.push_back(dir_rows[k].fixed ? dir_rows[k].want : p);
      send_beat(dir_rows[k].mode, dir_rows[k].target, dir_rows[k].length,
                dir_rows[k].tag_version, 1'b0);
    end
    req.valid <= 1'b0;
    drain();

    // Long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int k = 0; k < 30; k++)
        issue(rta_pkg::MODE_READ, $urandom_range(0, 17), 0, 0, 1'b0);
    join
    req.valid <= 1'b0;
    drain();

    // Random phases over several register settings, extremes included
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin
          write_reg(rta_pkg::CFG_SLOTS_IN_USE, 16); write_reg(rta_pkg::CFG_REGION_FLOOR, 0);
        end
        1: begin
          write_reg(rta_pkg::CFG_SLOTS_IN_USE, 1); write_reg(rta_pkg::CFG_REGION_FLOOR, 4096);
        end
        2: begin
          write_reg(rta_pkg::CFG_SLOTS_IN_USE, 31); write_reg(rta_pkg::CFG_REGION_FLOOR, 8191);
        end
        3: begin
          write_reg(rta_pkg::CFG_SLOTS_IN_USE, 0); write_reg(rta_pkg::CFG_REGION_FLOOR, 16);
        end
        default: begin
          write_reg(rta_pkg::CFG_SLOTS_IN_USE, $urandom_range(1, 31));
          write_reg(rta_pkg::CFG_REGION_FLOOR, $urandom_range(0, 600));
        end
      endcase
      for (int k = 0; k < 160; k++) begin
        m = 3'($urandom_range(0, 9));
        if (m > rta_pkg::MODE_READ && $urandom_range(0, 7) != 0) m = 3'($urandom_range(0, 5));
        // Mostly small lengths so the table fills and frees; few extremes
        case ($urandom_range(0, 9))
          0: len = $urandom_range(0, 8191);
          1: len = 0;
          default: len = $urandom_range(1, 400);
        endcase
        if (m == rta_pkg::MODE_AT_ADDR)
          tgt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 4096);
        else if (m == rta_pkg::MODE_RESIZE && $urandom_range(0, 2) == 0 && len > 50)
          tgt = $urandom_range(0, 17);
        else if ($urandom_range(0, 15) == 0) tgt = $urandom_range(0, 8191);
        else tgt = $urandom_range(0, 17);
        // Frees keep the table from staying full
        if (m == rta_pkg::MODE_RESIZE && $urandom_range(0, 1) == 0) len = 0;
        issue(m, tgt, len, $urandom_range(0, 255), 1'b1);
      end
      req.valid <= 1'b0;
      drain();
    end

    sending_done = 1'b1;
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/rta_pkg.sv
hdl/rta_intf.sv
hdl/rta_cell.sv
hdl/region_table_allocator.sv
tb/sv/tb_region_table_allocator.sv
